FILE: design/mmc_pkg.sv
package mmc_pkg;

    localparam int WORD_W = 16;
    localparam int PC_W   = 12;
    localparam int REG_AW = 3;
    localparam int PLEN_W = 8;

    typedef enum logic [3:0] {
        PH_FETCH   = 4'd0,
        PH_DECODE  = 4'd1,
        PH_ADDR    = 4'd2,
        PH_LW_MEM  = 4'd3,
        PH_LW_WB   = 4'd4,
        PH_SW_MEM  = 4'd5,
        PH_ADDI_WB = 4'd6,
        PH_R_EXEC  = 4'd7,
        PH_R_WB    = 4'd8,
        PH_JUMP    = 4'd10
    } phase_t;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_J     = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_AND = 3'd2;
    localparam logic [2:0] FN_OR  = 3'd3;

    // packed from msb down; tdata bit 0 is pc_value[0]
    typedef struct packed {
        logic [1:0]        pad;
        logic [WORD_W-1:0] mem_write_value;
        logic [7:0]        mem_write_address;
        logic              mem_write_valid;
        logic [WORD_W-1:0] reg_write_value;
        logic [REG_AW-1:0] reg_write_index;
        logic              reg_write_valid;
        logic              halted;
        logic [3:0]        phase;
        logic [PC_W-1:0]   pc_value;
    } result_t;

    function automatic logic [WORD_W-1:0] alu_op(input logic [2:0] fn,
                                                 input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        case (fn)
            FN_ADD:  r = a + b;
            FN_SUB:  r = a - b;
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/mmc_mem.sv
module mmc_mem
    import mmc_pkg::*;
#(
    parameter int WORDS = 256,
    parameter int AW    = 8
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mmc_regfile.sv
module mmc_regfile
    import mmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [REG_AW-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [REG_AW-1:0] raddr_a,
    input  logic [REG_AW-1:0] raddr_b,
    output logic [WORD_W-1:0] rdata_a,
    output logic [WORD_W-1:0] rdata_b
);

    localparam int DEPTH = 1 << REG_AW;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;
    logic              rv_a_reg;
    logic              rv_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_a_reg  <= 1'b0;
            rv_b_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rv_a_reg <= valid_reg[raddr_a];
                rv_b_reg <= valid_reg[raddr_b];
            end
        end
    end

    assign rdata_a = rv_a_reg ? rd_a_reg : '0;
    assign rdata_b = rv_b_reg ? rd_b_reg : '0;

endmodule

FILE: design/mmc_outbuf.sv
module mmc_outbuf
    import mmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_acc;
    logic    out_free;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || in_acc;
                skid_valid_reg <= 1'b0;
            end
            else if (in_acc)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (in_acc)
        begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: design/multicycle_mini_mips_core.sv
// Output: each beat's result is registered in the output buffer (skid register if stalled).
// Throughput: one beat per cycle while s_tready is high; each beat makes at most one access
//   to the single-port main memory and one access to the register file.
// Reset: PC, phase, IR, operands, ALU, MDR, registers and program_length clear, core halted;
//   main memory contents are undefined until loaded.
module multicycle_mini_mips_core
    import mmc_pkg::*;
#(
    parameter int MEMORY_WORDS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // load_address[7:0], load_word[23:8]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pc_value, phase, halted, reg_write_valid, reg_write_index,
                                   // reg_write_value, mem_write_valid, mem_write_address,
                                   // mem_write_value, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    // power-of-two depth
    localparam int AW   = $clog2(MEMORY_WORDS);
    localparam int LA_W = (AW > 8) ? AW : 8;

    phase_t            phase_reg, phase_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [WORD_W-1:0] ir_reg, ir_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] alu_reg, alu_next;
    logic [WORD_W-1:0] mdr_reg, mdr_next;
    logic [PLEN_W-1:0] plen_reg;
    logic              ir_pend_reg, ir_pend_next;
    logic              opnd_pend_reg, opnd_pend_next;
    logic              mdr_pend_reg, mdr_pend_next;

    logic              acc;
    logic              step;
    logic [1:0]        action;
    logic [7:0]        load_address;
    logic [WORD_W-1:0] load_word;
    logic [LA_W-1:0]   la_ext;

    logic [WORD_W-1:0] ir, opa, opb, mdr;
    logic [3:0]        op;
    logic [REG_AW-1:0] rs, rt, rd;
    logic [2:0]        fn;
    logic [WORD_W-1:0] imm;
    logic              addr_ok;

    logic              mem_en, mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic              rf_we, rf_re;
    logic [REG_AW-1:0] rf_waddr;
    logic [WORD_W-1:0] rf_wdata, rf_a, rf_b;

    result_t           res, out_res;

    assign acc          = s_tvalid && s_tready;
    assign action       = s_tuser;
    assign load_address = s_tdata[7:0];
    assign load_word    = s_tdata[23:8];
    assign la_ext       = LA_W'(load_address);
    assign step         = acc && (action == ACT_STEP) && !halt_reg;
    assign cfg_ready    = 1'b1;

    // read data is registered and lands in the cycle after issue; use it directly until copied
    assign ir  = ir_pend_reg   ? mem_rdata : ir_reg;
    assign opa = opnd_pend_reg ? rf_a      : a_reg;
    assign opb = opnd_pend_reg ? rf_b      : b_reg;
    assign mdr = mdr_pend_reg  ? mem_rdata : mdr_reg;

    assign op  = ir[15:12];
    assign rs  = ir[11:9];
    assign rt  = ir[8:6];
    assign rd  = ir[5:3];
    assign fn  = ir[2:0];
    assign imm = WORD_W'(ir[5:0]);

    assign addr_ok = !alu_reg[WORD_W-1] && (17'(alu_reg) < 17'(MEMORY_WORDS));

    always_comb
    begin
        phase_next     = phase_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        ir_next        = ir_pend_reg ? mem_rdata : ir_reg;
        a_next         = opa;
        b_next         = opb;
        alu_next       = alu_reg;
        mdr_next       = mdr;
        ir_pend_next   = 1'b0;
        opnd_pend_next = 1'b0;
        mdr_pend_next  = 1'b0;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = pc_reg[AW-1:0];
        mem_wdata      = load_word;
        rf_we          = 1'b0;
        rf_re          = 1'b0;
        rf_waddr       = rt;
        rf_wdata       = alu_reg;
        res            = '0;

        if (acc && action == ACT_LOAD)
        begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = la_ext[AW-1:0];
        end
        else if (acc && action == ACT_START)
        begin
            if (plen_reg != '0)
            begin
                halt_next = 1'b0;
            end
        end

        if (step)
        begin
            case (phase_reg)
                PH_FETCH:
                begin
                    mem_en       = 1'b1;
                    mem_addr     = pc_reg[AW-1:0];
                    ir_pend_next = 1'b1;
                    pc_next      = pc_reg + PC_W'(1);
                    phase_next   = PH_DECODE;
                end
                PH_DECODE:
                begin
                    rf_re          = 1'b1;
                    opnd_pend_next = 1'b1;
                    if (op == OP_RTYPE)
                        phase_next = PH_R_EXEC;
                    else if (op == OP_ADDI || op == OP_LW || op == OP_SW)
                        phase_next = PH_ADDR;
                    else if (op == OP_J)
                        phase_next = PH_JUMP;
                    else
                        phase_next = PH_FETCH;
                end
                PH_ADDR:
                begin
                    alu_next = opa + imm;
                    if (op == OP_ADDI)
                        phase_next = PH_ADDI_WB;
                    else if (op == OP_LW)
                        phase_next = PH_LW_MEM;
                    else if (op == OP_SW)
                        phase_next = PH_SW_MEM;
                    else
                        phase_next = PH_FETCH;
                end
                PH_LW_MEM:
                begin
                    if (addr_ok)
                    begin
                        mem_en        = 1'b1;
                        mem_addr      = alu_reg[AW-1:0];
                        mdr_pend_next = 1'b1;
                    end
                    phase_next = PH_LW_WB;
                end
                PH_LW_WB:
                begin
                    rf_we    = 1'b1;
                    rf_waddr = rt;
                    rf_wdata = mdr;
                    phase_next = PH_FETCH;
                end
                PH_SW_MEM:
                begin
                    if (addr_ok)
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = alu_reg[AW-1:0];
                        mem_wdata = opb;
                        res.mem_write_valid   = 1'b1;
                        res.mem_write_address = alu_reg[7:0];
                        res.mem_write_value   = opb;
                    end
                    phase_next = PH_FETCH;
                end
                PH_ADDI_WB:
                begin
                    rf_we      = 1'b1;
                    rf_waddr   = rt;
                    rf_wdata   = alu_reg;
                    phase_next = PH_FETCH;
                end
                PH_R_EXEC:
                begin
                    alu_next   = alu_op(fn, opa, opb);
                    phase_next = PH_R_WB;
                end
                PH_R_WB:
                begin
                    rf_we      = 1'b1;
                    rf_waddr   = rd;
                    rf_wdata   = alu_reg;
                    phase_next = PH_FETCH;
                end
                PH_JUMP:
                begin
                    pc_next    = ir[PC_W-1:0];
                    phase_next = PH_FETCH;
                end
                default:
                begin
                    phase_next = PH_FETCH;
                end
            endcase

            if (phase_next == PH_FETCH && pc_next >= PC_W'(plen_reg))
            begin
                halt_next = 1'b1;
            end
        end

        res.pc_value        = pc_next;
        res.phase           = phase_next;
        res.halted          = halt_next;
        res.reg_write_valid = rf_we;
        res.reg_write_index = rf_we ? rf_waddr : '0;
        res.reg_write_value = rf_we ? rf_wdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FETCH;
            pc_reg        <= '0;
            halt_reg      <= 1'b1;
            ir_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            alu_reg       <= '0;
            mdr_reg       <= '0;
            plen_reg      <= '0;
            ir_pend_reg   <= 1'b0;
            opnd_pend_reg <= 1'b0;
            mdr_pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            ir_reg        <= ir_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            alu_reg       <= alu_next;
            mdr_reg       <= mdr_next;
            ir_pend_reg   <= ir_pend_next;
            opnd_pend_reg <= opnd_pend_next;
            mdr_pend_reg  <= mdr_pend_next;
            if (cfg_valid && cfg_ready)
            begin
                plen_reg <= cfg_data;
            end
        end
    end

    mmc_mem #(
        .WORDS (MEMORY_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mmc_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .re      (rf_re),
        .raddr_a (rs),
        .raddr_b (rt),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    mmc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res;

`ifndef SYNTHESIS
    a_ir_copy_once: assert property (@(posedge clk) disable iff (!rst_n)
        ir_pend_reg |=> !ir_pend_reg)
        else $error("fetch issued while fetched word still pending");

    a_mdr_copy_once: assert property (@(posedge clk) disable iff (!rst_n)
        mdr_pend_reg |=> !mdr_pend_reg)
        else $error("load read issued while loaded word still pending");

    a_halt_at_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> (phase_reg == PH_FETCH))
        else $error("core halted away from fetch");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_res.reg_write_valid && out_res.mem_write_valid))
        else $error("beat reports register and memory write");

    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");
`endif

endmodule
